>>> rtl/core/qsm_pkg.sv
// shared types, widths and codes of the quadrature speed meter
package qsm_pkg;

   localparam int COUNT_WIDTH    = 32;
   localparam int RPM_FRAC_BITS  = 8;
   localparam int PPS_WIDTH      = 24;
   localparam int RPM_WIDTH      = 40;
   localparam int CPR_WIDTH      = 24;
   localparam int WINDOW_WIDTH   = 16;
   localparam int DIR_WIDTH      = 2;
   localparam int CSR_IDX_WIDTH  = 8;
   localparam int CSR_DATA_WIDTH = 24;
   localparam int SCALE_WIDTH    = 6;
   localparam int NUM_WIDTH      = PPS_WIDTH + SCALE_WIDTH + RPM_FRAC_BITS;
   localparam int STEP_WIDTH     = $clog2(NUM_WIDTH);
   localparam int FIFO_DEPTH     = 4;
   localparam int FIFO_PTR_WIDTH = $clog2(FIFO_DEPTH);

   localparam logic [SCALE_WIDTH-1:0]    SECONDS_PER_MINUTE = 6'd60;
   localparam logic [CPR_WIDTH-1:0]      CPR_RESET          = 24'd1;
   localparam logic [WINDOW_WIDTH-1:0]   WINDOW_RESET       = 16'd1000;
   localparam logic [PPS_WIDTH-1:0]      PPS_MAX            = '1;

   localparam logic [CSR_IDX_WIDTH-1:0]  CSR_COUNTS_PER_REV = 8'd0;
   localparam logic [CSR_IDX_WIDTH-1:0]  CSR_WINDOW_MS      = 8'd1;

   localparam logic [DIR_WIDTH-1:0]      DIR_NONE = 2'b00;
   localparam logic [DIR_WIDTH-1:0]      DIR_FWD  = 2'b01;
   localparam logic [DIR_WIDTH-1:0]      DIR_REV  = 2'b11;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] position;
      logic [DIR_WIDTH-1:0]   direction;
      logic [COUNT_WIDTH-1:0] delta;
      logic                   window_done;
   } qsm_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qsm_fifo_status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCALE,
      BK_DIVIDE,
      BK_EMIT
   } qsm_back_state_type;

endpackage

>>> rtl/core/qsm_if.sv
// request, response and register write channels of the quadrature speed meter
interface qsm_req_if import qsm_pkg::*; ();
   logic valid;
   logic ready;
   logic enc_a_level;
   logic enc_b_level;
   logic ms_tick;

   modport source (output valid, output enc_a_level, output enc_b_level, output ms_tick,
                   input ready);
   modport sink (input valid, input enc_a_level, input enc_b_level, input ms_tick,
                 output ready);
endinterface

interface qsm_rsp_if import qsm_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [COUNT_WIDTH-1:0] position;
   logic signed [DIR_WIDTH-1:0]   direction;
   logic [PPS_WIDTH-1:0]          pulses_per_sec;
   logic [RPM_WIDTH-1:0]          rpm_fixed;
   logic                          window_done;

   modport source (output valid, output position, output direction, output pulses_per_sec,
                   output rpm_fixed, output window_done, input ready);
   modport sink (input valid, input position, input direction, input pulses_per_sec,
                 input rpm_fixed, input window_done, output ready);
endinterface

interface qsm_csr_if import qsm_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_IDX_WIDTH-1:0]  reg_index;
   logic [CSR_DATA_WIDTH-1:0] data;

   modport source (output valid, output reg_index, output data, input ready);
   modport sink (input valid, input reg_index, input data, output ready);
endinterface

>>> rtl/core/qsm_fifo.sv
// short queue between the sample front and the speed back part
module qsm_fifo import qsm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  qsm_entry_type       push_entry,
   input  logic                pop,
   output qsm_entry_type       head_entry,
   output qsm_fifo_status_type status
);

   qsm_entry_type               mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_PTR_WIDTH:0]     fill_ff, fill_in;

   always_comb begin
      status.full  = (fill_ff == (FIFO_PTR_WIDTH+1)'(FIFO_DEPTH));
      status.empty = (fill_ff == '0);
      head_entry   = mem_ff[rd_ptr_ff];
      wr_ptr_in    = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in    = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in      = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

>>> rtl/core/qsm_front.sv
// sample front: edge decode, position count and window timing
module qsm_front import qsm_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   qsm_req_if.sink                 req,
   input  logic [WINDOW_WIDTH-1:0] window_ms,
   input  logic                    fifo_full,
   output logic                    push,
   output qsm_entry_type           push_entry
);

   logic                    prev_a_ff, prev_a_in;
   logic                    prev_b_ff, prev_b_in;
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;
   logic [COUNT_WIDTH-1:0]  delta_ff, delta_in;
   logic [DIR_WIDTH-1:0]    dir_ff, dir_in;
   logic [WINDOW_WIDTH-1:0] ticks_ff, ticks_in;

   logic                    rise_a, rise_b, step, step_up, close;
   logic [COUNT_WIDTH-1:0]  count_step, delta_step;
   logic [WINDOW_WIDTH-1:0] ticks_next;

   assign req.ready = !fifo_full;
   assign push      = req.valid && !fifo_full;

   always_comb begin
      rise_a  = req.enc_a_level && !prev_a_ff;
      rise_b  = req.enc_b_level && !prev_b_ff;
      // both rising: the two counts cancel, the channel b rule sets direction
      step    = rise_a ^ rise_b;
      step_up = rise_a ? (req.enc_a_level == req.enc_b_level)
                       : (req.enc_a_level != req.enc_b_level);

      count_step = count_ff;
      delta_step = delta_ff;
      dir_in     = dir_ff;
      if (rise_a && rise_b) begin
         dir_in = DIR_REV;
      end else if (step && step_up) begin
         count_step = count_ff + 1'b1;
         delta_step = delta_ff + 1'b1;
         dir_in     = DIR_FWD;
      end else if (step) begin
         count_step = count_ff - 1'b1;
         delta_step = delta_ff - 1'b1;
         dir_in     = DIR_REV;
      end

      ticks_next = (ticks_ff != '1) ? ticks_ff + 1'b1 : ticks_ff;
      close      = req.ms_tick && (ticks_next >= window_ms);
      ticks_in   = ticks_ff;
      if (close) begin
         ticks_in = '0;
      end else if (req.ms_tick) begin
         ticks_in = ticks_next;
      end

      count_in  = count_step;
      delta_in  = close ? '0 : delta_step;
      prev_a_in = req.enc_a_level;
      prev_b_in = req.enc_b_level;

      push_entry.position    = count_step;
      push_entry.direction   = dir_in;
      push_entry.delta       = delta_step;
      push_entry.window_done = close;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_a_ff <= 1'b0;
         prev_b_ff <= 1'b0;
         count_ff  <= '0;
         delta_ff  <= '0;
         dir_ff    <= DIR_NONE;
         ticks_ff  <= '0;
      end else if (push) begin
         prev_a_ff <= prev_a_in;
         prev_b_ff <= prev_b_in;
         count_ff  <= count_in;
         delta_ff  <= delta_in;
         dir_ff    <= dir_in;
         ticks_ff  <= ticks_in;
      end
   end

endmodule

>>> rtl/core/qsm_back.sv
// speed back part: pulse rate, bit-serial rpm divide and response register
module qsm_back import qsm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  qsm_entry_type        head_entry,
   input  logic                 fifo_empty,
   output logic                 pop,
   input  logic [CPR_WIDTH-1:0] counts_per_rev,
   qsm_rsp_if.source            rsp
);

   qsm_back_state_type      state_ff, state_in;
   logic [PPS_WIDTH-1:0]    pps_ff, pps_in;
   logic [RPM_WIDTH-1:0]    rpm_ff, rpm_in;
   logic [COUNT_WIDTH-1:0]  pend_pos_ff, pend_pos_in;
   logic [DIR_WIDTH-1:0]    pend_dir_ff, pend_dir_in;
   logic [NUM_WIDTH-1:0]    num_ff, num_in;
   logic [NUM_WIDTH-1:0]    quot_ff, quot_in;
   logic [CPR_WIDTH-1:0]    rem_ff, rem_in;
   logic [STEP_WIDTH-1:0]   step_ff, step_in;

   logic                    out_valid_ff, out_valid_in;
   logic [COUNT_WIDTH-1:0]  out_pos_ff, out_pos_in;
   logic [DIR_WIDTH-1:0]    out_dir_ff, out_dir_in;
   logic [PPS_WIDTH-1:0]    out_pps_ff, out_pps_in;
   logic [RPM_WIDTH-1:0]    out_rpm_ff, out_rpm_in;
   logic                    out_done_ff, out_done_in;

   logic                    out_free;
   logic [COUNT_WIDTH-1:0]  mag;
   logic [CPR_WIDTH:0]      trial;
   logic                    fits;
   logic [RPM_WIDTH-1:0]    rpm_result;

   assign rsp.valid          = out_valid_ff;
   assign rsp.position       = out_pos_ff;
   assign rsp.direction      = out_dir_ff;
   assign rsp.pulses_per_sec = out_pps_ff;
   assign rsp.rpm_fixed      = out_rpm_ff;
   assign rsp.window_done    = out_done_ff;

   always_comb begin
      out_free = !out_valid_ff || rsp.ready;

      mag = head_entry.delta[COUNT_WIDTH-1] ? -head_entry.delta : head_entry.delta;

      trial = {rem_ff, num_ff[NUM_WIDTH-1]};
      fits  = (trial >= {1'b0, counts_per_rev});

      rpm_result = (counts_per_rev == '0) ? '0 : RPM_WIDTH'(quot_ff);

      state_in     = state_ff;
      pop          = 1'b0;
      pps_in       = pps_ff;
      rpm_in       = rpm_ff;
      pend_pos_in  = pend_pos_ff;
      pend_dir_in  = pend_dir_ff;
      num_in       = num_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_pos_in   = out_pos_ff;
      out_dir_in   = out_dir_ff;
      out_pps_in   = out_pps_ff;
      out_rpm_in   = out_rpm_ff;
      out_done_in  = out_done_ff;

      case (state_ff)
         BK_IDLE: begin
            if (!fifo_empty && !head_entry.window_done && out_free) begin
               pop          = 1'b1;
               out_valid_in = 1'b1;
               out_pos_in   = head_entry.position;
               out_dir_in   = head_entry.direction;
               out_pps_in   = pps_ff;
               out_rpm_in   = rpm_ff;
               out_done_in  = 1'b0;
            end else if (!fifo_empty && head_entry.window_done) begin
               pop         = 1'b1;
               pend_pos_in = head_entry.position;
               pend_dir_in = head_entry.direction;
               // magnitude of the window change, saturated to the rate width
               pps_in      = (mag[COUNT_WIDTH-1:PPS_WIDTH] != '0) ? PPS_MAX
                                                                 : mag[PPS_WIDTH-1:0];
               state_in    = BK_SCALE;
            end
         end
         BK_SCALE: begin
            num_in   = (NUM_WIDTH'(pps_ff) * NUM_WIDTH'(SECONDS_PER_MINUTE)) << RPM_FRAC_BITS;
            quot_in  = '0;
            rem_in   = '0;
            step_in  = STEP_WIDTH'(NUM_WIDTH - 1);
            state_in = BK_DIVIDE;
         end
         BK_DIVIDE: begin
            // restoring divide, one quotient bit per cycle
            rem_in  = fits ? CPR_WIDTH'(trial - {1'b0, counts_per_rev})
                           : trial[CPR_WIDTH-1:0];
            quot_in = {quot_ff[NUM_WIDTH-2:0], fits};
            num_in  = num_ff << 1;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (out_free) begin
               rpm_in       = rpm_result;
               out_valid_in = 1'b1;
               out_pos_in   = pend_pos_ff;
               out_dir_in   = pend_dir_ff;
               out_pps_in   = pps_ff;
               out_rpm_in   = rpm_result;
               out_done_in  = 1'b1;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         pps_ff       <= '0;
         rpm_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pps_ff       <= pps_in;
         rpm_ff       <= rpm_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_pos_ff <= pend_pos_in;
      pend_dir_ff <= pend_dir_in;
      num_ff      <= num_in;
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      out_pos_ff  <= out_pos_in;
      out_dir_ff  <= out_dir_in;
      out_pps_ff  <= out_pps_in;
      out_rpm_ff  <= out_rpm_in;
      out_done_ff <= out_done_in;
   end

endmodule

>>> rtl/core/quadrature_speed_meter_top.sv
// Quadrature speed meter top level. Each request is one sample of encoder channels A and B
// with a millisecond tick flag, and each request yields exactly one response with position,
// last direction, pulses per second and rpm (8 fraction bits). Samples that close no window
// stream at one per clock while the back part is free. A sample that closes a window holds
// the back part in its scale, divide and emit states, the bit-serial rpm divider giving one
// quotient bit per cycle over 38 bits; a four-entry queue lets the front keep taking samples
// meanwhile, and responses always leave in request order. Register writes are always ready
// and are meant to be made only while the block is idle.
module quadrature_speed_meter_top import qsm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   qsm_req_if.sink   req_bus,
   qsm_rsp_if.source rsp_bus,
   qsm_csr_if.sink   csr_bus
);

   logic [CPR_WIDTH-1:0]    counts_per_rev_ff, counts_per_rev_in;
   logic [WINDOW_WIDTH-1:0] window_ms_ff, window_ms_in;

   logic                    push, pop;
   qsm_entry_type           push_entry, head_entry;
   qsm_fifo_status_type     fifo_status;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      counts_per_rev_in = counts_per_rev_ff;
      window_ms_in      = window_ms_ff;
      if (csr_bus.valid) begin
         case (csr_bus.reg_index)
            CSR_COUNTS_PER_REV: counts_per_rev_in = csr_bus.data[CPR_WIDTH-1:0];
            CSR_WINDOW_MS:      window_ms_in      = csr_bus.data[WINDOW_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counts_per_rev_ff <= CPR_RESET;
         window_ms_ff      <= WINDOW_RESET;
      end else begin
         counts_per_rev_ff <= counts_per_rev_in;
         window_ms_ff      <= window_ms_in;
      end
   end

   qsm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .window_ms  (window_ms_ff),
      .fifo_full  (fifo_status.full),
      .push       (push),
      .push_entry (push_entry)
   );

   qsm_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (fifo_status)
   );

   qsm_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_entry     (head_entry),
      .fifo_empty     (fifo_status.empty),
      .pop            (pop),
      .counts_per_rev (counts_per_rev_ff),
      .rsp            (rsp_bus)
   );

endmodule
